[hdl/ohlc_bar_aggregator_macros.svh]
// Assertion macros shared by the OHLC bar aggregator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef OHLC_BAR_AGGREGATOR_MACROS_SVH
`define OHLC_BAR_AGGREGATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OHLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OHLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ohlc_pkg.sv]
// Types, codes and helper functions for the OHLC bar aggregator.
// Depends on nothing.
package ohlc_pkg;

    localparam int TIME_W  = 14;
    localparam int PRICE_W = 24;
    localparam int QTY_W   = 16;
    localparam int VOL_W   = 32;

    typedef logic [1:0] t_colour;

    localparam logic    OP_TRADE = 1'b0;
    localparam logic    OP_READ  = 1'b1;

    localparam t_colour COLOUR_GREY  = 2'd0;
    localparam t_colour COLOUR_GREEN = 2'd1;
    localparam t_colour COLOUR_RED   = 2'd2;

    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]   volume;
    } t_bar;

    // Direction of a bar from its first and latest price.
    function automatic t_colour colour_of(input logic [PRICE_W-1:0] open_p,
                                          input logic [PRICE_W-1:0] close_p);
        t_colour c;
        if (close_p == open_p) begin
            c = COLOUR_GREY;
        end else if (close_p > open_p) begin
            c = COLOUR_GREEN;
        end else begin
            c = COLOUR_RED;
        end
        return c;
    endfunction

endpackage

[hdl/ohlc_bar_aggregator.sv]
// OHLC bar aggregator: an accepted request passes the divide, correction and update states before the result strobe.
// A new request is taken only while idle; busy stays high through the bucket divide, correction,
// and the read-modify-write of the single-port bar memory.
// Reset: synchronous active low; then a clearing pass over all NUM_BARS entries with busy high.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// Depends on ohlc_pkg and ohlc_bar_aggregator_macros.svh.
`include "ohlc_bar_aggregator_macros.svh"

module ohlc_bar_aggregator #(
    parameter int NUM_BARS     = 1024,
    parameter int BAR_INTERVAL = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [ohlc_pkg::TIME_W-1:0]   i_timestamp,
    input  logic [ohlc_pkg::PRICE_W-1:0]  i_price,
    input  logic [ohlc_pkg::QTY_W-1:0]    i_quantity,
    output logic                          o_result_valid,
    output logic                          o_bar_exists,
    output logic [ohlc_pkg::TIME_W-1:0]   o_bar_start,
    output logic [ohlc_pkg::PRICE_W-1:0]  o_open_price,
    output logic [ohlc_pkg::PRICE_W-1:0]  o_high_price,
    output logic [ohlc_pkg::PRICE_W-1:0]  o_low_price,
    output logic [ohlc_pkg::PRICE_W-1:0]  o_close_price,
    output logic [ohlc_pkg::VOL_W-1:0]    o_total_volume,
    output ohlc_pkg::t_colour             o_colour
);

    // Every bar lives in one memory word together with its valid flag. Since
    // the table is far too deep for per-entry valid flip-flops, reset starts
    // a sweep that writes an invalid word to every entry, one per cycle.
    localparam int TW     = ohlc_pkg::TIME_W;
    localparam int PW     = ohlc_pkg::PRICE_W;
    localparam int VW     = ohlc_pkg::VOL_W;
    localparam int AW     = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int BAR_W  = $bits(ohlc_pkg::t_bar);

    // The bucket is timestamp / BAR_INTERVAL. It is formed as a multiply by a
    // rounded-up reciprocal, which lands on the true quotient or one above it,
    // followed by a single compare-and-correct step.
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = TW + RECIP_W;
    localparam int IV_W      = 11;
    localparam int QD_W      = TW + IV_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + BAR_INTERVAL - 1) / BAR_INTERVAL);
    localparam logic [IV_W-1:0] INTERVAL = IV_W'(BAR_INTERVAL);
    localparam int CNT_W = 17;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FIX   = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;

    // Request captured at the accepting edge.
    logic                r_op;
    logic [TW-1:0]       r_ts;
    logic [PW-1:0]       r_price;
    logic [ohlc_pkg::QTY_W-1:0] r_qty;

    logic [PROD_W-1:0]   r_prod;
    logic [TW-1:0]       r_quot;
    logic [QD_W-1:0]     r_qd;
    logic [AW-1:0]       r_addr;
    logic [TW-1:0]       r_start;
    logic                r_in_range;

    ohlc_pkg::t_bar      r_mem [NUM_BARS];
    ohlc_pkg::t_bar      r_rdata;

    logic                r_result_valid;
    logic                r_exists;
    logic [TW-1:0]       r_bar_start;
    logic [PW-1:0]       r_open, r_high, r_low, r_close;
    logic [VW-1:0]       r_volume;
    ohlc_pkg::t_colour   r_colour;

    // Correction step signals.
    logic                fix_over;
    logic [TW-1:0]       fix_bucket;
    logic [QD_W-1:0]     fix_start;
    logic                fix_in_range;

    // Memory port control.
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    ohlc_pkg::t_bar      mem_wdata;

    // Update of the fetched bar.
    ohlc_pkg::t_bar      upd_bar;
    logic [VW:0]         vol_sum;
    logic                accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        fix_over     = (r_qd > QD_W'(r_ts));
        fix_bucket   = fix_over ? (r_quot - TW'(1)) : r_quot;
        fix_start    = fix_over ? (r_qd - QD_W'(INTERVAL)) : r_qd;
        fix_in_range = (CNT_W'(fix_bucket) < CNT_W'(NUM_BARS));
    end

    // The fetched bar after folding in a trade. A bar that was empty takes
    // the trade price in all four price fields.
    always_comb begin
        vol_sum = (VW+1)'(r_rdata.volume) + (VW+1)'(r_qty);
        upd_bar.valid = 1'b1;
        if (!r_rdata.valid) begin
            upd_bar.open_p  = r_price;
            upd_bar.high_p  = r_price;
            upd_bar.low_p   = r_price;
            upd_bar.close_p = r_price;
            upd_bar.volume  = VW'(r_qty);
        end else begin
            upd_bar.open_p  = r_rdata.open_p;
            upd_bar.high_p  = (r_price > r_rdata.high_p) ? r_price : r_rdata.high_p;
            upd_bar.low_p   = (r_price < r_rdata.low_p) ? r_price : r_rdata.low_p;
            upd_bar.close_p = r_price;
            upd_bar.volume  = vol_sum[VW] ? ohlc_pkg::VOL_MAX : vol_sum[VW-1:0];
        end
    end

    // The single write port serves the clearing sweep and the write-back of a
    // trade. Only one request is in flight, so a read never races a write to
    // the same entry.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = upd_bar;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_MOD && r_in_range && r_op == ohlc_pkg::OP_TRADE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_FIX) begin
            r_rdata <= r_mem[AW'(fix_bucket)];
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NUM_BARS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   n_state = S_FIX;
            S_FIX:   n_state = S_MOD;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr          <= n_clr;
            r_result_valid <= (r_state == S_MOD);
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_ts    <= i_timestamp;
            r_price <= i_price;
            r_qty   <= i_quantity;
            r_prod  <= PROD_W'(i_timestamp) * PROD_W'(DIV_RECIP);
        end
        if (r_state == S_DIV) begin
            r_quot <= r_prod[DIV_SHIFT +: TW];
            r_qd   <= QD_W'(r_prod[DIV_SHIFT +: TW]) * QD_W'(INTERVAL);
        end
        if (r_state == S_FIX) begin
            r_addr     <= AW'(fix_bucket);
            r_start    <= fix_start[TW-1:0];
            r_in_range <= fix_in_range;
        end
        if (r_state == S_MOD) begin
            r_bar_start <= r_start;
            if (!r_in_range) begin
                r_exists <= 1'b0;
                r_open   <= '0;
                r_high   <= '0;
                r_low    <= '0;
                r_close  <= '0;
                r_volume <= '0;
                r_colour <= ohlc_pkg::COLOUR_GREY;
            end else if (r_op == ohlc_pkg::OP_TRADE) begin
                r_exists <= 1'b1;
                r_open   <= upd_bar.open_p;
                r_high   <= upd_bar.high_p;
                r_low    <= upd_bar.low_p;
                r_close  <= upd_bar.close_p;
                r_volume <= upd_bar.volume;
                r_colour <= ohlc_pkg::colour_of(upd_bar.open_p, upd_bar.close_p);
            end else if (r_rdata.valid) begin
                r_exists <= 1'b1;
                r_open   <= r_rdata.open_p;
                r_high   <= r_rdata.high_p;
                r_low    <= r_rdata.low_p;
                r_close  <= r_rdata.close_p;
                r_volume <= r_rdata.volume;
                r_colour <= ohlc_pkg::colour_of(r_rdata.open_p, r_rdata.close_p);
            end else begin
                r_exists <= 1'b0;
                r_open   <= '0;
                r_high   <= '0;
                r_low    <= '0;
                r_close  <= '0;
                r_volume <= '0;
                r_colour <= ohlc_pkg::COLOUR_GREY;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_bar_exists   = r_exists;
    assign o_bar_start    = r_bar_start;
    assign o_open_price   = r_open;
    assign o_high_price   = r_high;
    assign o_low_price    = r_low;
    assign o_close_price  = r_close;
    assign o_total_volume = r_volume;
    assign o_colour       = r_colour;

    // A result appears only right after the update step of a request.
    `OHLC_ASSERT_NOW(a_result_after_update, i_clk, i_rst_n, r_result_valid, $past(r_state) == S_MOD, "result strobe without a finished request")
    // An accepted request always starts the divide step.
    `OHLC_ASSERT_NEXT(a_accept_to_div, i_clk, i_rst_n, accept, r_state == S_DIV, "accepted request did not enter the divide step")
    // While a result is shown, the block is ready for the next request.
    `OHLC_ASSERT_NOW(a_ready_with_result, i_clk, i_rst_n, r_result_valid, !busy, "busy while a result is presented")
    // The colour agrees with the open and close prices of a reported bar.
    `OHLC_ASSERT_NOW(a_colour_match, i_clk, i_rst_n, r_result_valid && r_exists, (r_colour == ohlc_pkg::COLOUR_GREY) == (r_open == r_close), "colour disagrees with open and close")
    // An empty bar reports zero prices and volume.
    `OHLC_ASSERT_NOW(a_empty_bar_zero, i_clk, i_rst_n, r_result_valid && !r_exists, r_open == '0 && r_close == '0 && r_volume == '0, "empty bar with nonzero fields")

endmodule

[tb/ohlc_bar_aggregator_tb.sv]
// Self-checking testbench for the OHLC bar aggregator: directed, volume and random requests.
// A behavioral copy of the bar table predicts every result; depends on ohlc_pkg and the RTL only.
`timescale 1ns / 100ps

module ohlc_bar_aggregator_tb;

    localparam int TIME_W  = ohlc_pkg::TIME_W;
    localparam int PRICE_W = ohlc_pkg::PRICE_W;
    localparam int QTY_W   = ohlc_pkg::QTY_W;
    localparam int VOL_W   = ohlc_pkg::VOL_W;

    typedef ohlc_pkg::t_colour t_colour;

    localparam int NUM_BARS     = 1024;
    localparam int BAR_INTERVAL = 10;

    // Highest timestamp whose bucket still falls inside the table.
    localparam int LAST_TS      = NUM_BARS * BAR_INTERVAL - 1;
    localparam int TS_MAX       = (1 << TIME_W) - 1;

    localparam int RANDOM_ITEMS = 1680;
    // Enough full-size quantities to carry the volume well past 16 bits.
    localparam int ACCUM_TRADES = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_LIMIT = 30;
    // The limit lies well above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 200_000;

    // One bar report as it appears on the result ports.
    typedef struct {
        logic               exists;
        logic [TIME_W-1:0]  start;
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]   volume;
        t_colour            colour;
    } t_bar_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [TIME_W-1:0]  i_timestamp;
    logic [PRICE_W-1:0] i_price;
    logic [QTY_W-1:0]   i_quantity;
    logic               o_result_valid;
    logic               o_bar_exists;
    logic [TIME_W-1:0]  o_bar_start;
    logic [PRICE_W-1:0] o_open_price;
    logic [PRICE_W-1:0] o_high_price;
    logic [PRICE_W-1:0] o_low_price;
    logic [PRICE_W-1:0] o_close_price;
    logic [VOL_W-1:0]   o_total_volume;
    t_colour            o_colour;

    ohlc_bar_aggregator #(
        .NUM_BARS     (NUM_BARS),
        .BAR_INTERVAL (BAR_INTERVAL)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_timestamp    (i_timestamp),
        .i_price        (i_price),
        .i_quantity     (i_quantity),
        .o_result_valid (o_result_valid),
        .o_bar_exists   (o_bar_exists),
        .o_bar_start    (o_bar_start),
        .o_open_price   (o_open_price),
        .o_high_price   (o_high_price),
        .o_low_price    (o_low_price),
        .o_close_price  (o_close_price),
        .o_total_volume (o_total_volume),
        .o_colour       (o_colour)
    );

    // Shadow copy of the bar table. The price and volume entries are only
    // looked at once the held flag of their bucket is set.
    bit                 bar_held  [NUM_BARS];
    logic [PRICE_W-1:0] bar_first [NUM_BARS];
    logic [PRICE_W-1:0] bar_top   [NUM_BARS];
    logic [PRICE_W-1:0] bar_bottom[NUM_BARS];
    logic [PRICE_W-1:0] bar_last  [NUM_BARS];
    logic [VOL_W-1:0]   bar_volume[NUM_BARS];

    // Bar reports still owed by the block, oldest first.
    t_bar_report pending_bars[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Sender pacing: requests go out in bursts, and the first request of
    // each burst waits up to gap_max idle cycles.
    int unsigned burst_left;
    int unsigned gap_max;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Folds one request into the shadow table and returns the report that
    // the block must produce for it. Buckets beyond the table are ignored
    // and reported as empty bars, as are reads of buckets with no trade.
    function automatic t_bar_report predict_bar(input logic               op,
                                                input logic [TIME_W-1:0]  ts,
                                                input logic [PRICE_W-1:0] price,
                                                input logic [QTY_W-1:0]   qty);
        t_bar_report rep;
        int unsigned bucket;
        logic [VOL_W:0] sum;
        bucket        = ts / BAR_INTERVAL;
        rep           = '{default: '0};
        rep.start     = TIME_W'(bucket * BAR_INTERVAL);
        if (bucket >= NUM_BARS) begin
            return rep;
        end
        if (op == ohlc_pkg::OP_TRADE) begin
            if (!bar_held[bucket]) begin
                bar_held[bucket]   = 1'b1;
                bar_first[bucket]  = price;
                bar_top[bucket]    = price;
                bar_bottom[bucket] = price;
                bar_last[bucket]   = price;
                bar_volume[bucket] = VOL_W'(qty);
            end else begin
                if (price > bar_top[bucket]) begin
                    bar_top[bucket] = price;
                end
                if (price < bar_bottom[bucket]) begin
                    bar_bottom[bucket] = price;
                end
                bar_last[bucket] = price;
                // Volume sticks at its maximum instead of wrapping.
                sum = {1'b0, bar_volume[bucket]} + (VOL_W + 1)'(qty);
                bar_volume[bucket] = sum[VOL_W] ? ohlc_pkg::VOL_MAX : sum[VOL_W-1:0];
            end
        end
        if (!bar_held[bucket]) begin
            return rep;
        end
        rep.exists  = 1'b1;
        rep.open_p  = bar_first[bucket];
        rep.high_p  = bar_top[bucket];
        rep.low_p   = bar_bottom[bucket];
        rep.close_p = bar_last[bucket];
        rep.volume  = bar_volume[bucket];
        if (rep.close_p == rep.open_p) begin
            rep.colour = ohlc_pkg::COLOUR_GREY;
        end else if (rep.close_p > rep.open_p) begin
            rep.colour = ohlc_pkg::COLOUR_GREEN;
        end else begin
            rep.colour = ohlc_pkg::COLOUR_RED;
        end
        return rep;
    endfunction

    function automatic void check_field(input string       name,
                                        input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        end
    endfunction

    // Sends one request. The task is entered just after the edge that took
    // the previous request (or while start is low), so start is either held
    // high for the next request of a burst or dropped for a gap here, never
    // both in one step. On return start is still high; whoever stops sending
    // must drop it with release_bus.
    task automatic send_request(input logic               op,
                                input logic [TIME_W-1:0]  ts,
                                input logic [PRICE_W-1:0] price,
                                input logic [QTY_W-1:0]   qty);
        int unsigned pause;
        pause = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            pause      = $urandom_range(0, gap_max);
        end
        burst_left--;
        @(negedge i_clk);
        if (pause != 0) begin
            start = 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        start       = 1'b1;
        i_op        = op;
        i_timestamp = ts;
        i_price     = price;
        i_quantity  = qty;
        // The request is taken at the first rising edge with busy low; that
        // includes the clearing pass that follows reset.
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pending_bars.push_back(predict_bar(op, ts, price, qty));
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Field extremes, both operations, reads of empty bars, buckets beyond
    // the table, and every color.
    task automatic test_directed_bars();
        gap_max = 3;
        // Bucket 0: zero price and quantity, then the full-scale values.
        send_request(ohlc_pkg::OP_TRADE, 14'd0, 24'h000000, 16'h0000);
        send_request(ohlc_pkg::OP_TRADE, 14'd9, 24'hFFFFFF, 16'hFFFF);
        send_request(ohlc_pkg::OP_TRADE, 14'd3, 24'h000000, 16'hFFFF);
        // Price and quantity must be ignored on a read.
        send_request(ohlc_pkg::OP_READ, 14'd7, 24'hFFFFFF, 16'hFFFF);
        // A bucket with no trade yet reads back as an empty bar.
        send_request(ohlc_pkg::OP_READ, 14'd4321, 24'h5A5A5A, 16'hA5A5);
        // The last bucket of the table: red, green and red again.
        send_request(ohlc_pkg::OP_TRADE, 14'(LAST_TS), 24'h800000, 16'h1234);
        send_request(ohlc_pkg::OP_TRADE, 14'(LAST_TS - 9), 24'h7FFFFF, 16'h0001);
        send_request(ohlc_pkg::OP_TRADE, 14'(LAST_TS - 4), 24'h900000, 16'h0002);
        send_request(ohlc_pkg::OP_TRADE, 14'(LAST_TS - 8), 24'h000100, 16'h0003);
        send_request(ohlc_pkg::OP_READ, 14'(LAST_TS - 9), 24'h000000, 16'h0000);
        // The neighbor of the last bucket was never traded.
        send_request(ohlc_pkg::OP_READ, 14'(LAST_TS - 10), 24'h000000, 16'h0000);
        // First bucket beyond the table, and the largest timestamp: both are
        // ignored and report an empty bar.
        send_request(ohlc_pkg::OP_TRADE, 14'(LAST_TS + 1), 24'h000555, 16'h004D);
        send_request(ohlc_pkg::OP_READ, 14'(LAST_TS + 1), 24'h000000, 16'h0000);
        send_request(ohlc_pkg::OP_TRADE, 14'(TS_MAX), 24'hFFFFFF, 16'hFFFF);
        send_request(ohlc_pkg::OP_READ, 14'(TS_MAX), 24'hFFFFFF, 16'hFFFF);
        send_request(ohlc_pkg::OP_READ, 14'd0, 24'h000000, 16'h0000);
        // Grey bar whose close returns to the open after a move up.
        send_request(ohlc_pkg::OP_TRADE, 14'd20, 24'h123456, 16'h000A);
        send_request(ohlc_pkg::OP_TRADE, 14'd24, 24'h123457, 16'h000B);
        send_request(ohlc_pkg::OP_TRADE, 14'd29, 24'h123456, 16'h000C);
        send_request(ohlc_pkg::OP_READ, 14'd25, 24'h000000, 16'h0000);
        release_bus();
    endtask

    // Piles full-size quantities into one bucket so that the volume carries
    // well past the width of a single quantity, then reads the bar back.
    task automatic test_volume_accumulation();
        logic [TIME_W-1:0] base;
        gap_max = 1;
        base    = 14'd4000;
        for (int n = 0; n < ACCUM_TRADES; n++) begin
            send_request(ohlc_pkg::OP_TRADE,
                         base + 14'($urandom_range(0, BAR_INTERVAL - 1)),
                         PRICE_W'($urandom), 16'hFFFF);
        end
        send_request(ohlc_pkg::OP_TRADE, base + 14'd1, 24'h000001, 16'h0001);
        send_request(ohlc_pkg::OP_TRADE, base + 14'd2, 24'hFFFFFE, 16'hFFFF);
        send_request(ohlc_pkg::OP_READ, base + 14'd9, 24'h000000, 16'h0000);
        release_bus();
    endtask

    // Mostly trades into a small window of hot buckets so that bars collect
    // many updates, with reads mixed in, scattered buckets, buckets beyond
    // the table, and a pacing that changes every few hundred requests.
    task automatic test_random_trading();
        int unsigned        hot_base;
        int unsigned        pick;
        logic [PRICE_W-1:0] level;
        logic               op;
        logic [TIME_W-1:0]  ts;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        hot_base = 0;
        level    = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) begin
                hot_base = $urandom_range(0, LAST_TS - 99);
                level    = PRICE_W'($urandom);
                // Zero gives a long stretch with the sender never idle.
                gap_max  = $urandom_range(0, 7);
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                ts = 14'(hot_base + $urandom_range(0, 99));
            end else if (pick < 86) begin
                ts = 14'($urandom_range(0, LAST_TS));
            end else if (pick < 93) begin
                ts = 14'($urandom_range(LAST_TS + 1, TS_MAX));
            end else begin
                ts = 14'($urandom_range(0, TS_MAX));
            end
            op = ($urandom_range(0, 99) < 20) ? ohlc_pkg::OP_READ : ohlc_pkg::OP_TRADE;
            // Prices wander around a level so high and low keep moving.
            if ($urandom_range(0, 99) < 80) begin
                price = level ^ PRICE_W'($urandom_range(0, 1023));
            end else begin
                price = PRICE_W'($urandom);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                qty = '0;
            end else if (pick == 1) begin
                qty = '1;
            end else begin
                qty = QTY_W'($urandom);
            end
            send_request(op, ts, price, qty);
        end
        release_bus();
    endtask

    // Every strobed result is matched against the oldest outstanding report.
    always @(posedge i_clk) begin : result_check
        t_bar_report want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_bars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $error("result strobe with no request outstanding");
                end
            end else begin
                want = pending_bars.pop_front();
                check_field("bar_exists",   32'(want.exists),  32'(o_bar_exists));
                check_field("bar_start",    32'(want.start),   32'(o_bar_start));
                check_field("open_price",   32'(want.open_p),  32'(o_open_price));
                check_field("high_price",   32'(want.high_p),  32'(o_high_price));
                check_field("low_price",    32'(want.low_p),   32'(o_low_price));
                check_field("close_price",  32'(want.close_p), 32'(o_close_price));
                check_field("total_volume", want.volume,       o_total_volume);
                check_field("colour",       32'(want.colour),  32'(o_colour));
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_op           = ohlc_pkg::OP_TRADE;
        i_timestamp    = '0;
        i_price        = '0;
        i_quantity     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        gap_max        = 0;
        // The shadow table starts with every bucket empty, like the block
        // after its clearing pass.
        foreach (bar_held[k]) begin
            bar_held[k] = 1'b0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_bars();
        test_volume_accumulation();
        test_random_trading();

        // Let the last reports come out, then watch a little longer for
        // strobes that nobody asked for.
        wait (pending_bars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/ohlc_pkg.sv
hdl/ohlc_bar_aggregator.sv
tb/ohlc_bar_aggregator_tb.sv
